[hdl/idta_pkg.sv]
// Shared types and constants for the integer to decimal ASCII formatter.
package idta_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_VALUE_W  = 32;
    localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int ND_W        = $clog2(NUM_DIGITS + 1);
    localparam int LEN_W       = 4;

    localparam logic       CMD_SIGNED   = 1'b0;
    localparam logic       CMD_UNSIGNED = 1'b1;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;

    typedef logic [VALUE_WIDTH-1:0] t_mag;

    typedef struct packed {
        logic                  cmd;
        logic [IN_VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0]       char_code;
        logic             last;
        logic [LEN_W-1:0] length;
    } t_out;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_bcd_xfer;

endpackage

[hdl/idta_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module idta_dabble (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  idta_pkg::t_mag      i_mag,
    input  logic                i_neg,
    output logic                o_ready,
    output logic                o_done,
    output idta_pkg::t_bcd_xfer o_result,
    input  logic                i_take
);
    import idta_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_mag             r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic             r_neg;
    logic [BCD_W-1:0] n_bcd;

    always_comb begin
        logic [BCD_W-1:0] adj;
        adj = r_bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
    end

    assign o_ready         = !r_busy && !r_done;
    assign o_done          = r_done;
    assign o_result.neg    = r_neg;
    assign o_result.bcd    = r_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_done) begin
            if (i_take) begin
                r_done <= 1'b0;
            end
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(VALUE_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_bcd <= n_bcd;
            r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
        end else if (o_ready && i_start) begin
            r_bcd <= '0;
            r_bin <= i_mag;
            r_neg <= i_neg;
        end
    end

endmodule

[hdl/idta_emit.sv]
// Leading-zero scan and character output, one digit per unstalled cycle.
module idta_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  idta_pkg::t_bcd_xfer i_xfer,
    output logic                o_take,
    output logic                o_valid,
    output idta_pkg::t_out      o_data,
    input  logic                i_ready
);
    import idta_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]       r_state;
    logic [BCD_W-1:0] r_bcd;
    logic [ND_W-1:0]  r_nd;
    logic             r_neg;
    logic             r_sign;
    logic [LEN_W-1:0] r_len;
    logic [3:0]       top_digit;

    assign top_digit = r_bcd[BCD_W-1 -: 4];
    assign o_take    = (r_state == ST_IDLE) && i_load;
    assign o_valid   = (r_state == ST_SEND);

    always_comb begin
        o_data.char_code = r_sign ? ASCII_MINUS : (ASCII_ZERO + {4'd0, top_digit});
        o_data.last      = !r_sign && (r_nd == ND_W'(1));
        o_data.length    = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_load) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (top_digit != 4'd0 || r_nd == ND_W'(1)) begin
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (i_ready && !r_sign && r_nd == ND_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_load) begin
                    r_bcd <= i_xfer.bcd;
                    r_neg <= i_xfer.neg;
                    r_nd  <= ND_W'(NUM_DIGITS);
                end
            end
            ST_SCAN: begin
                if (top_digit != 4'd0 || r_nd == ND_W'(1)) begin
                    r_sign <= r_neg;
                    r_len  <= LEN_W'(r_nd) + LEN_W'(r_neg);
                end else begin
                    r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_nd  <= r_nd - 1'b1;
                end
            end
            ST_SEND: begin
                if (i_ready) begin
                    if (r_sign) begin
                        r_sign <= 1'b0;
                    end else begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_nd  <= r_nd - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

[hdl/integer_to_decimal_ascii_core.sv]
// Top level of the integer to decimal ASCII formatter.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is one
// 32-bit value plus a cmd bit (0 = signed, 1 = unsigned).
// Output channel (o_out_valid / i_out_ready / o_out_data): one transaction per
// character, most significant first, '-' first for negative signed values.
// Every character carries the run length; last marks the final character.
//
// A value passes through the bit-serial BCD converter, is handed over to the
// output stage, is scanned there for leading zeros, and then leaves one
// character per cycle while the receiver is ready. The converter shift loop
// sets the throughput while the receiver keeps up: it is ready for the next
// value in the cycle after handing over, so converting and sending overlap.
//
// Reset (synchronous, active low) drops any value in flight. When the
// receiver stalls, the current character holds and the converter holds its
// finished result, after which o_in_ready stays low.
module integer_to_decimal_ascii_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  idta_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output idta_pkg::t_out o_out_data
);
    import idta_pkg::*;

    t_mag      raw;
    t_mag      mag;
    logic      neg;
    logic      conv_done;
    logic      emit_take;
    t_bcd_xfer xfer;

    always_comb begin
        raw = t_mag'(i_in_data.value);
        neg = (i_in_data.cmd == CMD_SIGNED) && raw[VALUE_WIDTH-1];
        mag = neg ? (~raw + 1'b1) : raw;
    end

    idta_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid),
        .i_mag    (mag),
        .i_neg    (neg),
        .o_ready  (o_in_ready),
        .o_done   (conv_done),
        .o_result (xfer),
        .i_take   (emit_take)
    );

    idta_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (conv_done),
        .i_xfer  (xfer),
        .o_take  (emit_take),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule

[hdl/idta_checker.sv]
// Port-level checks for the formatter, bound to the top level.
module idta_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input idta_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input idta_pkg::t_out o_out_data
);
    import idta_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.char_code == ASCII_MINUS |-> !o_out_data.last)
        else $error("minus sign marked as last character");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last
        |=> o_out_valid && $stable(o_out_data.length)
            && o_out_data.char_code != ASCII_MINUS)
        else $error("character run broken or length changed");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.length != '0)
        else $error("zero run length");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind integer_to_decimal_ascii_core idta_checker u_idta_checker (.*);
